/* design/rbfe_pkg.sv */
// ----------------------------------------------------------------------------
// rbfe_pkg
// Shared constants, codes and helpers for the ring buffer frame extractor.
// ----------------------------------------------------------------------------
package rbfe_pkg;

   // Ring and search limits.
   localparam int RING_DEPTH    = 128;
   localparam int MAX_HEADERS   = 5;
   localparam int MAX_FRAME_LEN = 64;
   localparam int STALE_POLLS   = 3;

   localparam int PTR_W   = $clog2(RING_DEPTH);
   localparam int HCNT_W  = $clog2(MAX_HEADERS + 1);
   localparam int FLEN_CAP = (MAX_FRAME_LEN < RING_DEPTH - 1) ? MAX_FRAME_LEN : RING_DEPTH - 1;
   localparam int STALE_W = 2;
   localparam int LEN_W   = 9;
   localparam int MIN_AVAIL = 5;

   // Sync header bytes and length overhead.
   localparam logic [7:0] SYNC_A = 8'h5A;
   localparam logic [7:0] SYNC_B = 8'hA5;
   localparam logic [LEN_W-1:0] LEN_OVERHEAD = 9'd3;

   // Command codes.
   localparam logic CMD_STORE = 1'b0;
   localparam logic CMD_POLL  = 1'b1;

   // Status codes of a result beat.
   typedef enum logic [2:0] {
      ST_STORED  = 3'd0,
      ST_OVERRUN = 3'd1,
      ST_WAIT    = 3'd2,
      ST_FRAME   = 3'd3,
      ST_DROP    = 3'd4,
      ST_JUNK    = 3'd5
   } status_type;

   // Pointer plus offset, wrapped at the ring depth (offset below the depth).
   function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] p,
                                                 input logic [PTR_W-1:0] x);
      logic [PTR_W:0] s;
      s = {1'b0, p} + {1'b0, x};
      if (s >= (PTR_W+1)'(RING_DEPTH)) begin
         s = s - (PTR_W+1)'(RING_DEPTH);
      end
      return s[PTR_W-1:0];
   endfunction

endpackage

/* design/rbfe_ring.sv */
// ----------------------------------------------------------------------------
// rbfe_ring
// Byte ring storage: one write port, one registered read port. Entries that
// were never written since reset read as zero.
// ----------------------------------------------------------------------------
module rbfe_ring (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_en,
   input  logic [rbfe_pkg::PTR_W-1:0] wr_addr,
   input  logic [7:0]                 wr_data,
   input  logic                       rd_en,
   input  logic [rbfe_pkg::PTR_W-1:0] rd_addr,
   output logic [7:0]                 rd_data
);
   import rbfe_pkg::*;

   logic [7:0]            mem_ff [RING_DEPTH];
   logic [RING_DEPTH-1:0] vld_ff;
   logic [7:0]            q_ff;
   logic                  qv_ff;

   // Storage array and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_ff <= mem_ff[rd_addr];
      end
   end

   // Written flags, cleared at reset so the ring reads as all zeros.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         qv_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            qv_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_data = qv_ff ? q_ff : 8'd0;

endmodule

/* design/ring_buffer_frame_extractor.sv */
// ----------------------------------------------------------------------------
// ring_buffer_frame_extractor
// Stores received bytes in a ring and deframes sync/length/checksum frames.
// ----------------------------------------------------------------------------
// Usage:
// The req_ channel carries one beat per command. A store beat writes
// req_rx_byte into the ring and yields one rsp_ beat (stored or overrun) in
// the next cycle, so bytes can stream at one every cycle while rsp_ready is
// high. A poll beat runs one analysis pass, reading the unread bytes and one
// more, one per cycle through its single read port. A frame that passes the
// length check is summed from its length byte to its end; with a zero sum
// and the frame store not full, it goes out as frame_byte beats, each byte
// read from the ring and then sent. rsp_last marks the final beat of each
// command. No new command is accepted until every beat of the current one
// has been taken. Low rsp_ready holds the result in the output register and
// pauses frame delivery. Reset empties the ring, zeroes its contents and
// clears the stale count; commands are accepted in the first cycle after it.
// ----------------------------------------------------------------------------
module ring_buffer_frame_extractor (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_command,
   input  logic [7:0] req_rx_byte,
   input  logic       req_frame_store_full,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_status,
   output logic [7:0] rsp_frame_byte,
   output logic       rsp_last
);
   import rbfe_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_SCAN     = 7'b0000010,
      S_DECIDE   = 7'b0000100,
      S_SUM      = 7'b0001000,
      S_CHECK    = 7'b0010000,
      S_DLV_RD   = 7'b0100000,
      S_DLV_WAIT = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   logic [PTR_W-1:0]  wp_ff, wp_in, rp_ff, rp_in, avail_ff, avail_in;
   logic [PTR_W-1:0]  iss_ff, iss_in, didx_ff, didx_in;
   logic              iss_done_ff, iss_done_in, dv_ff, dv_in;
   logic [STALE_W-1:0] stale_ff, stale_in;
   logic              full_ff, full_in;
   logic [7:0]        prev_ff, prev_in, len0_ff, len0_in, sum_ff, sum_in;
   logic [HCNT_W-1:0] nhdr_ff, nhdr_in;
   logic [PTR_W-1:0]  h0_ff, h0_in, head1_ff, head1_in, hlast_ff, hlast_in;
   logic              match_ff, match_in, lenpend_ff, lenpend_in;
   logic [PTR_W-1:0]  flen_ff, flen_in;
   logic              rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;

   logic              wr_en, rd_en;
   logic [PTR_W-1:0]  rd_addr;
   logic [7:0]        rd_data;

   logic              out_free;
   logic [PTR_W-1:0]  wp_next, avail_now, start_idx, rp_at_h0, rem, dist1, dist_last;
   logic [LEN_W-1:0]  flen_w;
   logic [STALE_W-1:0] stale_up;
   logic              is_hdr;

   rbfe_ring u_ring (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data (req_rx_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;

   // Derived pointer arithmetic.
   always_comb begin
      wp_next   = (wp_ff == PTR_W'(RING_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
      avail_now = (wp_ff >= rp_ff) ? wp_ff - rp_ff
                                   : PTR_W'((PTR_W+1)'(RING_DEPTH) + wp_ff - rp_ff);
      start_idx = didx_ff - 1'b1;
      rp_at_h0  = ring_add(rp_ff, h0_ff);
      rem       = avail_ff - h0_ff;
      dist1     = head1_ff - h0_ff;
      dist_last = hlast_ff - h0_ff;
      flen_w    = {1'b0, len0_ff} + LEN_OVERHEAD;
      stale_up  = stale_ff + 1'b1;
      is_hdr    = (didx_ff != '0) && (didx_ff != avail_ff) &&
                  (prev_ff == SYNC_A) && (rd_data == SYNC_B);
   end

   // Main sequencer.
   always_comb begin
      state_in    = state_ff;
      wp_in       = wp_ff;
      rp_in       = rp_ff;
      avail_in    = avail_ff;
      iss_in      = iss_ff;
      iss_done_in = iss_done_ff;
      dv_in       = 1'b0;
      didx_in     = didx_ff;
      stale_in    = stale_ff;
      full_in     = full_ff;
      prev_in     = prev_ff;
      len0_in     = len0_ff;
      sum_in      = sum_ff;
      nhdr_in     = nhdr_ff;
      h0_in       = h0_ff;
      head1_in    = head1_ff;
      hlast_in    = hlast_ff;
      match_in    = match_ff;
      lenpend_in  = lenpend_ff;
      flen_in     = flen_ff;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = ring_add(rp_ff, iss_ff);

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               rsp_byte_in = 8'd0;
               rsp_last_in = 1'b1;
               if (req_command == CMD_STORE) begin
                  rsp_valid_in = 1'b1;
                  if (wp_next == rp_ff) begin
                     rsp_status_in = ST_OVERRUN;
                  end else begin
                     wr_en         = 1'b1;
                     wp_in         = wp_next;
                     rsp_status_in = ST_STORED;
                  end
               end else if (avail_now < PTR_W'(MIN_AVAIL)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_WAIT;
               end else begin
                  avail_in    = avail_now;
                  full_in     = req_frame_store_full;
                  iss_in      = '0;
                  iss_done_in = 1'b0;
                  nhdr_in     = '0;
                  match_in    = 1'b0;
                  lenpend_in  = 1'b0;
                  state_in    = S_SCAN;
               end
            end
         end

         // Walk the unread bytes plus one for a trailing length byte.
         S_SCAN: begin
            if (!iss_done_ff) begin
               rd_en   = 1'b1;
               dv_in   = 1'b1;
               didx_in = iss_ff;
               if (iss_ff == avail_ff) begin
                  iss_done_in = 1'b1;
               end else begin
                  iss_in = iss_ff + 1'b1;
               end
            end
            if (dv_ff) begin
               prev_in = rd_data;
               if (lenpend_ff) begin
                  len0_in    = rd_data;
                  lenpend_in = 1'b0;
               end
               if (is_hdr && (nhdr_ff < HCNT_W'(MAX_HEADERS))) begin
                  nhdr_in = nhdr_ff + 1'b1;
                  if (nhdr_ff == '0) begin
                     h0_in      = start_idx;
                     lenpend_in = 1'b1;
                  end else begin
                     if (nhdr_ff == HCNT_W'(1)) begin
                        head1_in = start_idx;
                     end
                     hlast_in = start_idx;
                     if (LEN_W'(start_idx - h0_ff) == flen_w) begin
                        match_in = 1'b1;
                     end
                  end
               end
               if (didx_ff == avail_ff) begin
                  state_in = S_DECIDE;
               end
            end
         end

         // Judge the first header's length against the data and later headers.
         S_DECIDE: begin
            rsp_byte_in = 8'd0;
            rsp_last_in = 1'b1;
            flen_in     = flen_w[PTR_W-1:0];
            state_in    = S_IDLE;
            rp_in       = rp_at_h0;
            if (nhdr_ff == '0) begin
               rp_in         = wp_ff;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_JUNK;
            end else if (flen_w > LEN_W'(FLEN_CAP)) begin
               stale_in      = '0;
               rp_in         = ring_add(rp_at_h0, PTR_W'(2));
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_DROP;
            end else if ((nhdr_ff == HCNT_W'(1) && flen_w <= LEN_W'(rem)) ||
                         (nhdr_ff != HCNT_W'(1) && (flen_w == LEN_W'(rem) || match_ff))) begin
               stale_in    = '0;
               iss_in      = PTR_W'(2);
               iss_done_in = 1'b0;
               sum_in      = 8'd0;
               state_in    = S_SUM;
            end else if (nhdr_ff == HCNT_W'(1)) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_WAIT;
            end else if (flen_w > LEN_W'(dist_last)) begin
               rsp_valid_in = 1'b1;
               if (stale_up >= STALE_W'(STALE_POLLS)) begin
                  stale_in      = '0;
                  rp_in         = ring_add(rp_at_h0, dist1);
                  rsp_status_in = ST_DROP;
               end else begin
                  stale_in      = stale_up;
                  rsp_status_in = ST_WAIT;
               end
            end else begin
               rp_in         = ring_add(rp_at_h0, dist1);
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_DROP;
            end
         end

         // Sum from the length byte through the end of the frame.
         S_SUM: begin
            if (!iss_done_ff) begin
               rd_en = 1'b1;
               dv_in = 1'b1;
               if (iss_ff == flen_ff - 1'b1) begin
                  iss_done_in = 1'b1;
               end else begin
                  iss_in = iss_ff + 1'b1;
               end
            end
            if (dv_ff) begin
               sum_in = sum_ff + rd_data;
               if (iss_done_ff) begin
                  state_in = S_CHECK;
               end
            end
         end

         S_CHECK: begin
            if (sum_ff != 8'd0 || full_ff) begin
               rp_in         = ring_add(rp_ff, flen_ff);
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_DROP;
               rsp_byte_in   = 8'd0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end else begin
               iss_in   = '0;
               state_in = S_DLV_RD;
            end
         end

         // Deliver the frame byte by byte, reading each byte once the output is free.
         S_DLV_RD: begin
            if (out_free) begin
               rd_en    = 1'b1;
               state_in = S_DLV_WAIT;
            end
         end

         S_DLV_WAIT: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_FRAME;
            rsp_byte_in   = rd_data;
            rsp_last_in   = (iss_ff == flen_ff - 1'b1);
            if (iss_ff == flen_ff - 1'b1) begin
               rp_in    = ring_add(rp_ff, flen_ff);
               state_in = S_IDLE;
            end else begin
               iss_in   = iss_ff + 1'b1;
               state_in = S_DLV_RD;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         stale_ff     <= '0;
         dv_ff        <= 1'b0;
         iss_done_ff  <= 1'b0;
         lenpend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         stale_ff     <= stale_in;
         dv_ff        <= dv_in;
         iss_done_ff  <= iss_done_in;
         lenpend_ff   <= lenpend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      avail_ff      <= avail_in;
      iss_ff        <= iss_in;
      didx_ff       <= didx_in;
      full_ff       <= full_in;
      prev_ff       <= prev_in;
      len0_ff       <= len0_in;
      sum_ff        <= sum_in;
      nhdr_ff       <= nhdr_in;
      h0_ff         <= h0_in;
      head1_ff      <= head1_in;
      hlast_ff      <= hlast_in;
      match_ff      <= match_in;
      flen_ff       <= flen_in;
      rsp_status_ff <= rsp_status_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_frame_byte = rsp_byte_ff;
   assign rsp_last       = rsp_last_ff;

endmodule
